>>> design/tmee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmee_pkg
// Shared types, constants and the state relabelling table for the engine.
// ----------------------------------------------------------------------------
package tmee_pkg;

    localparam int TAPE_LEN   = 256;
    localparam int TAPE_AW    = $clog2(TAPE_LEN);
    localparam int POS_W      = TAPE_AW + 1;
    localparam int SEEN_BITS  = 16;
    localparam int SEEN_DEPTH = 1 << SEEN_BITS;
    localparam int ACC_W      = 34;
    localparam int WORD_W     = 64;
    localparam int NUM_IMAGES = 5;
    localparam logic [7:0] STEP_LIMIT_RESET = 8'd170;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SYM,
        ST_CLEAR,
        ST_RUN,
        ST_WRITE,
        ST_READ_WORD,
        ST_SEEN_RD,
        ST_SEEN_CHK,
        ST_OUT,
        ST_SEEN_INIT
    } state_t;

    // symmetry unit handshake
    typedef struct packed {
        logic       done;
        logic       canon;
        logic [2:0] mult;
    } sym_status_t;

    // image j of the code, position p takes nibble from src, relabeled
    function automatic logic [31:0] image_of(input logic [31:0] code,
                                             input logic [2:0] j);
        logic [2:0] src;
        logic [3:0] nib;
        logic [1:0] ns;
        logic [31:0] img;
        img = '0;
        for (int p = 0; p < 8; p++)
        begin
            case (j)
                3'd0: src = (p == 2) ? 3'd4 : (p == 3) ? 3'd5 : (p == 4) ? 3'd2 :
                            (p == 5) ? 3'd3 : 3'(p);
                3'd1: src = (p < 2) ? 3'(p + 2) : (p < 4) ? 3'(p - 2) : 3'(p);
                3'd2: src = (p < 4) ? 3'(p + 2) : (p < 6) ? 3'(p - 4) : 3'(p);
                3'd3: src = (p < 2) ? 3'(p + 4) : (p < 6) ? 3'(p - 2) : 3'(p);
                default: src = (p < 2) ? 3'(p + 4) : (p < 4) ? 3'(p) :
                               (p < 6) ? 3'(p - 4) : 3'(p);
            endcase
            nib = code[4*(7-src) +: 4];
            case (j)
                3'd0: ns = (nib[3:2] == 2'd1) ? 2'd2 : (nib[3:2] == 2'd2) ? 2'd1 : nib[3:2];
                3'd1: ns = (nib[3:2] == 2'd2) ? 2'd3 : (nib[3:2] == 2'd3) ? 2'd2 : nib[3:2];
                3'd2: ns = (nib[3:2] == 2'd1) ? 2'd2 : (nib[3:2] == 2'd2) ? 2'd3 :
                           (nib[3:2] == 2'd3) ? 2'd1 : 2'd0;
                3'd3: ns = (nib[3:2] == 2'd1) ? 2'd3 : (nib[3:2] == 2'd2) ? 2'd1 :
                           (nib[3:2] == 2'd3) ? 2'd2 : 2'd0;
                default: ns = (nib[3:2] == 2'd1) ? 2'd3 : (nib[3:2] == 2'd3) ? 2'd1 :
                              nib[3:2];
            endcase
            img[4*(7-p) +: 4] = {ns, nib[1:0]};
        end
        return img;
    endfunction

endpackage
`default_nettype wire

>>> design/tmee_symmetry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmee_symmetry
// Builds one symmetric image a cycle with one shared compare unit and
// reports multiplicity and canonical flag.
// ----------------------------------------------------------------------------
module tmee_symmetry (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        code,
    output tmee_pkg::sym_status_t   status
);

    logic [2:0]  idx_reg, idx_next;
    logic        busy_reg, busy_next;
    logic        canon_reg, canon_next;
    logic [2:0]  fixed_reg, fixed_next;
    logic        done_reg, done_next;
    logic [31:0] img;

    assign img = tmee_pkg::image_of(code, idx_reg);

    // image sweep
    always_comb
    begin
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        canon_next = canon_reg;
        fixed_next = fixed_reg;
        done_next  = 1'b0;
        if (start)
        begin
            idx_next   = '0;
            busy_next  = 1'b1;
            canon_next = 1'b1;
            fixed_next = 3'd1;
        end
        else if (busy_reg)
        begin
            if (img < code)
                canon_next = 1'b0;
            if (img == code)
                fixed_next = fixed_reg + 3'd1;
            idx_next = idx_reg + 3'd1;
            if (idx_reg == 3'(tmee_pkg::NUM_IMAGES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            canon_reg <= 1'b0;
            fixed_reg <= 3'd1;
            done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            canon_reg <= canon_next;
            fixed_reg <= fixed_next;
            done_reg  <= done_next;
        end
    end

    // 6 / fixed, fixed is 1, 2, 3 or 6
    always_comb
    begin
        status.done  = done_reg;
        status.canon = canon_reg;
        case (fixed_reg)
            3'd1:    status.mult = 3'd6;
            3'd2:    status.mult = 3'd3;
            3'd3:    status.mult = 3'd2;
            default: status.mult = 3'd1;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (fixed_reg == 3'd1 || fixed_reg == 3'd2 ||
                      fixed_reg == 3'd3 || fixed_reg == 3'd6));

endmodule
`default_nettype wire

>>> design/turing_machine_enumeration_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// turing_machine_enumeration_engine
// Symmetry check, tape simulation and halting word bookkeeping for
// 4-state 2-symbol machines.
// ----------------------------------------------------------------------------
// One code is taken at a time. After reset a pass clears the 65536-entry
// seen-word memory, one entry a cycle, before the first code is accepted.
// Each code first gets a symmetry check (one image per cycle in a shared
// compare unit); a non-canonical code then goes straight to the result.
// A canonical code clears the 256-cell tape, then runs each transition as a
// tape memory read, then a write, for up to step_limit-1 transitions. On a
// halt it reads the word back one cell a cycle from the rightmost visited
// cell and, unless the word is too long, makes one seen-word lookup.
// The result sits in an output register; the next code is accepted once it
// has been taken.
module turing_machine_enumeration_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] machine_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             canonical,
    output logic [2:0]       multiplicity,
    output logic             halted,
    output logic [7:0]       steps_taken,
    output logic [63:0]      tape_word,
    output logic             word_too_long,
    output logic             first_seen,
    output logic [33:0]      halt_total
);

    tmee_pkg::state_t state_reg, state_next;
    tmee_pkg::sym_status_t sym_status;

    logic [7:0]  step_limit_reg;
    logic [31:0] code_reg, code_next;
    logic [tmee_pkg::POS_W-1:0] head_reg, head_next, right_reg, right_next;
    logic [tmee_pkg::POS_W-1:0] idx_reg, idx_next;
    logic [1:0]  mstate_reg, mstate_next;
    logic [7:0]  counter_reg, counter_next;
    logic [2:0]  mult_reg, mult_next;
    logic        canon_reg, canon_next;
    logic        halted_reg, halted_next;
    logic [63:0] word_reg, word_next;
    logic        too_long_reg, too_long_next;
    logic        first_reg, first_next;
    logic [tmee_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [tmee_pkg::SEEN_BITS-1:0] seen_cnt_reg, seen_cnt_next;
    logic        sym_start;

    // tape memory
    logic        tape_mem [tmee_pkg::TAPE_LEN];
    logic        tape_we, tape_wdata, tape_rdata;
    logic [tmee_pkg::TAPE_AW-1:0] tape_waddr, tape_raddr;

    // seen-word memory
    logic        seen_mem [tmee_pkg::SEEN_DEPTH];
    logic        seen_we, seen_wdata, seen_rdata;
    logic [tmee_pkg::SEEN_BITS-1:0] seen_waddr, seen_raddr;

    logic [3:0]  entry;
    logic [tmee_pkg::POS_W-1:0] head_mv;

    tmee_symmetry u_sym (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sym_start),
        .code   (code_reg),
        .status (sym_status)
    );

    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_waddr] <= tape_wdata;
        tape_rdata <= tape_mem[tape_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        seen_rdata <= seen_mem[seen_raddr];
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == tmee_pkg::ST_IDLE);
    assign out_valid = (state_reg == tmee_pkg::ST_OUT);

    assign entry = code_reg[4*{mstate_reg, tape_rdata} +: 4];

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        head_next     = head_reg;
        right_next    = right_reg;
        idx_next      = idx_reg;
        mstate_next   = mstate_reg;
        counter_next  = counter_reg;
        mult_next     = mult_reg;
        canon_next    = canon_reg;
        halted_next   = halted_reg;
        word_next     = word_reg;
        too_long_next = too_long_reg;
        first_next    = first_reg;
        acc_next      = acc_reg;
        seen_cnt_next = seen_cnt_reg;
        sym_start     = 1'b0;
        tape_we       = 1'b0;
        tape_waddr    = idx_reg[tmee_pkg::TAPE_AW-1:0];
        tape_wdata    = 1'b0;
        tape_raddr    = head_reg[tmee_pkg::TAPE_AW-1:0];
        seen_we       = 1'b0;
        seen_waddr    = seen_cnt_reg;
        seen_wdata    = 1'b0;
        seen_raddr    = word_reg[tmee_pkg::SEEN_BITS-1:0];
        head_mv       = head_reg;
        case (state_reg)
            tmee_pkg::ST_SEEN_INIT:
            begin
                seen_we = 1'b1;
                seen_cnt_next = seen_cnt_reg + 1'b1;
                if (seen_cnt_reg == tmee_pkg::SEEN_BITS'(tmee_pkg::SEEN_DEPTH - 1))
                    state_next = tmee_pkg::ST_IDLE;
            end
            tmee_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next  = machine_code;
                    state_next = tmee_pkg::ST_SYM;
                    sym_start  = 1'b1;
                end
            end
            tmee_pkg::ST_SYM:
            begin
                if (sym_status.done)
                begin
                    mult_next     = sym_status.mult;
                    canon_next    = sym_status.canon;
                    halted_next   = 1'b0;
                    word_next     = '0;
                    too_long_next = 1'b0;
                    first_next    = 1'b0;
                    counter_next  = 8'd1;
                    idx_next      = '0;
                    head_next     = tmee_pkg::POS_W'(1);
                    right_next    = tmee_pkg::POS_W'(1);
                    mstate_next   = 2'd0;
                    state_next    = sym_status.canon ? tmee_pkg::ST_CLEAR : tmee_pkg::ST_OUT;
                end
            end
            tmee_pkg::ST_CLEAR:
            begin
                tape_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == tmee_pkg::POS_W'(tmee_pkg::TAPE_LEN - 1))
                    state_next = tmee_pkg::ST_RUN;
            end
            tmee_pkg::ST_RUN:
            begin
                // tape read issued at head; decide whether to step
                if (head_reg == '0 || counter_reg >= step_limit_reg)
                begin
                    if (head_reg == '0)
                    begin
                        halted_next = 1'b1;
                        acc_next    = acc_reg + tmee_pkg::ACC_W'(mult_reg);
                        word_next   = 64'd1;
                        idx_next    = right_reg;
                        state_next  = tmee_pkg::ST_READ_WORD;
                    end
                    else
                        state_next = tmee_pkg::ST_OUT;
                end
                else
                    state_next = tmee_pkg::ST_WRITE;
            end
            tmee_pkg::ST_WRITE:
            begin
                tape_we     = 1'b1;
                tape_waddr  = head_reg[tmee_pkg::TAPE_AW-1:0];
                tape_wdata  = entry[1];
                mstate_next = entry[3:2];
                if (entry[0])
                    head_mv = head_reg - 1'b1;
                else if (head_reg != tmee_pkg::POS_W'(tmee_pkg::TAPE_LEN - 1))
                    head_mv = head_reg + 1'b1;
                head_next = head_mv;
                tape_raddr = head_mv[tmee_pkg::TAPE_AW-1:0];
                if (head_mv > right_reg)
                    right_next = head_mv;
                counter_next = counter_reg + 8'd1;
                state_next   = tmee_pkg::ST_RUN;
            end
            tmee_pkg::ST_READ_WORD:
            begin
                // read address idx, data arrives in the next cycle
                tape_raddr = idx_reg[tmee_pkg::TAPE_AW-1:0];
                if (idx_reg != right_reg)
                    word_next = {word_reg[62:0], tape_rdata};
                if (idx_reg == '0)
                begin
                    if (right_reg + 1'b1 > tmee_pkg::POS_W'(tmee_pkg::SEEN_BITS))
                    begin
                        too_long_next = 1'b1;
                        state_next    = tmee_pkg::ST_OUT;
                    end
                    else
                        state_next = tmee_pkg::ST_SEEN_RD;
                end
                else
                    idx_next = idx_reg - 1'b1;
            end
            tmee_pkg::ST_SEEN_RD:
            begin
                state_next = tmee_pkg::ST_SEEN_CHK;
            end
            tmee_pkg::ST_SEEN_CHK:
            begin
                if (!seen_rdata)
                begin
                    first_next = 1'b1;
                    seen_we    = 1'b1;
                    seen_waddr = word_reg[tmee_pkg::SEEN_BITS-1:0];
                    seen_wdata = 1'b1;
                end
                state_next = tmee_pkg::ST_OUT;
            end
            tmee_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = tmee_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tmee_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmee_pkg::ST_SEEN_INIT;
            step_limit_reg <= tmee_pkg::STEP_LIMIT_RESET;
            acc_reg        <= '0;
            seen_cnt_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            seen_cnt_reg <= seen_cnt_next;
            if (cfg_valid)
                step_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        head_reg     <= head_next;
        right_reg    <= right_next;
        idx_reg      <= idx_next;
        mstate_reg   <= mstate_next;
        counter_reg  <= counter_next;
        mult_reg     <= mult_next;
        canon_reg    <= canon_next;
        halted_reg   <= halted_next;
        word_reg     <= word_next;
        too_long_reg <= too_long_next;
        first_reg    <= first_next;
    end

    assign canonical     = canon_reg;
    assign multiplicity  = mult_reg;
    assign halted        = halted_reg;
    assign steps_taken   = halted_reg || canon_reg ? counter_reg - 8'd1 : 8'd0;
    assign tape_word     = word_reg;
    assign word_too_long = too_long_reg;
    assign first_seen    = first_reg;
    assign halt_total    = acc_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmee_pkg::ST_WRITE) |-> (head_reg != '0));
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmee_pkg::ST_OUT && !canon_reg) |-> !halted_reg);
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(acc_reg));
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmee_pkg::ST_RUN) |-> (head_reg <= right_reg));

endmodule
`default_nettype wire

>>> test/tb_turing_machine_enumeration_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turing_machine_enumeration_engine
// Self-checking bench: machine codes are driven through a queue-fed driver,
// results are compared against a behavioral copy of the symmetry check,
// tape run and seen-word bookkeeping, over several step limits and idling
// phases.
// ----------------------------------------------------------------------------
module tb_turing_machine_enumeration_engine;

    typedef struct packed {
        logic        canon;
        logic [2:0]  mult;
        logic        halt;
        logic [7:0]  steps;
        logic [63:0] word;
        logic        too_long;
        logic        first;
        logic [33:0] total;
    } machine_result_t;

    localparam int WATCHDOG_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] machine_code;
    logic        out_valid;
    logic        out_ready;
    logic        canonical;
    logic [2:0]  multiplicity;
    logic        halted;
    logic [7:0]  steps_taken;
    logic [63:0] tape_word;
    logic        word_too_long;
    logic        first_seen;
    logic [33:0] halt_total;

    turing_machine_enumeration_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .machine_code(machine_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .canonical(canonical), .multiplicity(multiplicity), .halted(halted),
        .steps_taken(steps_taken), .tape_word(tape_word),
        .word_too_long(word_too_long), .first_seen(first_seen),
        .halt_total(halt_total)
    );

    // predictor state
    logic [7:0]      pred_limit;
    logic [33:0]     pred_total;
    logic            pred_seen [0:tmee_pkg::SEEN_DEPTH-1];
    logic            pred_tape [0:tmee_pkg::TAPE_LEN-1];

    logic [31:0]     code_queue [$];
    machine_result_t result_queue [$];
    int              mismatch_count;
    int              result_count;
    int              halt_count;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              watchdog;
    logic            cfg_pending;
    logic [7:0]      cfg_value;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // symmetric image of a code under one state relabelling
    function automatic logic [31:0] relabel_image(logic [31:0] code, int j);
        int src_map [5][8] = '{'{0,1,4,5,2,3,6,7}, '{2,3,0,1,4,5,6,7},
                               '{2,3,4,5,0,1,6,7}, '{4,5,0,1,2,3,6,7},
                               '{4,5,2,3,0,1,6,7}};
        int lab_map [5][4] = '{'{0,2,1,3}, '{0,1,3,2}, '{0,2,3,1},
                               '{0,3,1,2}, '{0,3,2,1}};
        logic [31:0] img;
        logic [3:0]  nib;
        logic [1:0]  ns;
        img = '0;
        for (int p = 0; p < 8; p++)
        begin
            nib = code[4*(7-src_map[j][p]) +: 4];
            ns = 2'(lab_map[j][nib[3:2]]);
            img[4*(7-p) +: 4] = {ns, nib[1:0]};
        end
        return img;
    endfunction

    // full behavior of one machine code
    function automatic machine_result_t run_machine(logic [31:0] code);
        machine_result_t r;
        logic [31:0] img;
        logic [31:0] minimum;
        int fixed;
        int head;
        int rightmost;
        int counter;
        logic [1:0] st;
        logic [3:0] nib;
        logic [tmee_pkg::SEEN_BITS-1:0] idx;
        r = '0;
        minimum = code;
        fixed = 1;
        for (int j = 0; j < 5; j++)
        begin
            img = relabel_image(code, j);
            if (img < minimum)
                minimum = img;
            if (img == code)
                fixed++;
        end
        r.mult = 3'(6 / fixed);
        r.canon = (code == minimum);
        if (r.canon)
        begin
            for (int i = 0; i < tmee_pkg::TAPE_LEN; i++)
                pred_tape[i] = 1'b0;
            head = 1;
            rightmost = 1;
            st = 2'd0;
            counter = 1;
            while (head != 0 && counter < int'(pred_limit))
            begin
                nib = code[4*(2*st + pred_tape[head]) +: 4];
                st = nib[3:2];
                pred_tape[head] = nib[1];
                if (nib[0])
                    head--;
                else if (head + 1 < tmee_pkg::TAPE_LEN)
                    head++;
                if (head > rightmost)
                    rightmost = head;
                counter++;
            end
            r.steps = 8'(counter - 1);
            if (head == 0)
            begin
                r.halt = 1'b1;
                pred_total = pred_total + 34'(r.mult);
                r.word = 64'd1;
                for (int i = rightmost; i > 0; i--)
                    r.word = {r.word[62:0], pred_tape[i]};
                if (rightmost + 1 > tmee_pkg::SEEN_BITS)
                    r.too_long = 1'b1;
                else
                begin
                    idx = r.word[tmee_pkg::SEEN_BITS-1:0];
                    if (!pred_seen[idx])
                    begin
                        r.first = 1'b1;
                        pred_seen[idx] = 1'b1;
                    end
                end
            end
        end
        r.total = pred_total;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 result_count, field, got, want);
        mismatch_count++;
    endtask

    // driver: input and configuration beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            machine_code <= '0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;
            else if (cfg_pending && !cfg_valid)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_value;
            end
            if (!in_valid || in_ready)
            begin
                if (code_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    machine_code <= code_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // predict on each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            result_queue = {result_queue, run_machine(machine_code)};
        if (rst_n && cfg_valid && cfg_ready)
            pred_limit = cfg_data;
    end

    // monitor: compare result beats, random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $display("unexpected result beat");
                    mismatch_count++;
                end
                else
                begin
                    machine_result_t w;
                    w = result_queue.pop_front();
                    if (canonical !== w.canon)
                        report_mismatch("canonical", 64'(canonical), 64'(w.canon));
                    if (multiplicity !== w.mult)
                        report_mismatch("multiplicity", 64'(multiplicity), 64'(w.mult));
                    if (halted !== w.halt)
                        report_mismatch("halted", 64'(halted), 64'(w.halt));
                    if (steps_taken !== w.steps)
                        report_mismatch("steps_taken", 64'(steps_taken), 64'(w.steps));
                    if (tape_word !== w.word)
                        report_mismatch("tape_word", tape_word, w.word);
                    if (word_too_long !== w.too_long)
                        report_mismatch("word_too_long", 64'(word_too_long),
                                        64'(w.too_long));
                    if (first_seen !== w.first)
                        report_mismatch("first_seen", 64'(first_seen), 64'(w.first));
                    if (halt_total !== w.total)
                        report_mismatch("halt_total", 64'(halt_total), 64'(w.total));
                    if (w.halt)
                        halt_count++;
                end
                result_count++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on beats of any kind
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    // random code biased toward small state numbers so more codes are canonical
    function automatic logic [31:0] random_code();
        logic [31:0] c;
        c = $urandom;
        if ($urandom_range(3) != 0)
            for (int e = 0; e < 8; e++)
                if ($urandom_range(2) == 0)
                    c[4*e+2 +: 2] = 2'd0;
        return c;
    endfunction

    task automatic wait_drained();
        while (code_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] value);
        cfg_value = value;
        cfg_pending = 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        cfg_pending = 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] limit, int idle, int stall, int count);
        wait_drained();
        write_limit(limit);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            code_queue = {code_queue, random_code()};
    endtask

    initial
    begin
        int idle_set [4] = '{0, 50, 0, 37};
        int stall_set [4] = '{0, 0, 50, 37};
        logic [7:0] limit_set [6] = '{8'd255, 8'd1, 8'd0, 8'd40, 8'd170, 8'd255};
        rst_n = 1'b0;
        cfg_pending = 1'b0;
        cfg_value = '0;
        mismatch_count = 0;
        result_count = 0;
        halt_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        watchdog = 0;
        pred_limit = tmee_pkg::STEP_LIMIT_RESET;
        pred_total = '0;
        for (int i = 0; i < tmee_pkg::SEEN_DEPTH; i++)
            pred_seen[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed codes at the reset step limit
        code_queue = {code_queue, 32'h0000_0000};
        code_queue = {code_queue, 32'hFFFF_FFFF};
        code_queue = {code_queue, 32'h0000_0001};
        code_queue = {code_queue, 32'h0000_0003};
        code_queue = {code_queue, 32'h0000_0013};
        code_queue = {code_queue, 32'h0000_0012};
        code_queue = {code_queue, 32'h0000_0021};
        code_queue = {code_queue, 32'h0000_0023};
        code_queue = {code_queue, 32'h0000_0031};
        code_queue = {code_queue, 32'h1111_1111};
        code_queue = {code_queue, 32'h8888_8888};
        code_queue = {code_queue, 32'h5555_5555};
        code_queue = {code_queue, 32'hAAAA_AAAA};
        code_queue = {code_queue, 32'h0000_0002};
        code_queue = {code_queue, 32'h0000_0000};
        code_queue = {code_queue, 32'h0000_0051};
        code_queue = {code_queue, 32'h0000_0501};
        code_queue = {code_queue, 32'h0000_0301};

        // random phases across step limits and idling patterns
        for (int ph = 0; ph < 6; ph++)
            run_phase(limit_set[ph], idle_set[ph % 4], stall_set[ph % 4], 130);
        wait_drained();
        $display("ran %0d machine codes, %0d halted, over %0d step limit settings",
                 result_count, halt_count, 7);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
design/tmee_pkg.sv
design/tmee_symmetry.sv
design/turing_machine_enumeration_engine.sv
test/tb_turing_machine_enumeration_engine.sv
